### hw/rtl/i2a_pkg.sv
// Shared types and constants for the integer-to-ASCII formatter.
// Holds the kind codes, character constants, controller/datapath command and
// status structs, and the character lookup functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

   // Conversion kinds carried on the input tuser field.
   localparam logic [2:0] OP_SDEC = 3'd0;
   localparam logic [2:0] OP_UDEC = 3'd1;
   localparam logic [2:0] OP_LHEX = 3'd2;
   localparam logic [2:0] OP_UHEX = 3'd3;
   localparam logic [2:0] OP_PTR  = 3'd4;

   localparam int VALUE_W    = 64;
   localparam int NUM_DIGITS = 20;
   localparam int DIGITS_W   = NUM_DIGITS * 4;
   localparam int CNT_W      = 6;
   localparam int NIL_LEN    = 5;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h78;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_dec;
      logic       load_hex;
      logic       negate;
      logic       dabble;
      logic       step;
      logic       emit;
      logic       use_digit;
      logic       last;
      logic       upper;
      logic [7:0] lit_char;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic val_neg;
      logic val_zero;
      logic top_zero;
      logic out_free;
   } status_type;

   // ASCII character for one hex or decimal digit.
   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
      logic [7:0] ch;
      if (digit < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, digit};
      end else if (upper) begin
         ch = 8'h41 + {4'd0, digit - 4'd10};
      end else begin
         ch = 8'h61 + {4'd0, digit - 4'd10};
      end
      return ch;
   endfunction

   // Characters of the null-pointer text.
   function automatic logic [7:0] nil_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h28;
         3'd1:    ch = 8'h6E;
         3'd2:    ch = 8'h69;
         3'd3:    ch = 8'h6C;
         default: ch = 8'h29;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/i2a_datapath.sv
// Datapath of the integer-to-ASCII formatter: magnitude shift register,
// BCD/hex digit register with double-dabble, and the result output register.
// Depends on i2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2a_datapath
   import i2a_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [7:0]               rsp_char,
   output logic                     rsp_last
);

   logic [VALUE_W-1:0]  mag_ff, mag_in;
   logic [DIGITS_W-1:0] dig_ff, dig_in;
   logic [DIGITS_W-1:0] adj;
   logic                valid_ff, valid_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;
   logic [3:0]          top_digit;

   assign top_digit = dig_ff[DIGITS_W-1 -: 4];

   // Add-3 correction of every BCD digit ahead of the shift.
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         adj[d*4 +: 4] = (dig_ff[d*4 +: 4] >= 4'd5) ? dig_ff[d*4 +: 4] + 4'd3
                                                     : dig_ff[d*4 +: 4];
      end
   end

   // Next values of the magnitude and digit registers.
   always_comb begin
      mag_in = mag_ff;
      dig_in = dig_ff;
      if (cmd.load_dec) begin
         mag_in = cmd.negate ? (~req_value + {{(VALUE_W-1){1'b0}}, 1'b1}) : req_value;
         dig_in = '0;
      end else if (cmd.load_hex) begin
         dig_in = {{(DIGITS_W-VALUE_W){1'b0}}, req_value};
      end else if (cmd.dabble) begin
         dig_in = {adj[DIGITS_W-2:0], mag_ff[VALUE_W-1]};
         mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
      end else if (cmd.step) begin
         dig_in = {dig_ff[DIGITS_W-5:0], 4'd0};
      end
   end

   // Output register: loaded on an emit, freed when the transfer completes.
   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         char_in  = cmd.use_digit ? digit_char(top_digit, cmd.upper) : cmd.lit_char;
         last_in  = cmd.last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      dig_ff  <= dig_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign status.val_neg  = req_value[VALUE_W-1];
   assign status.val_zero = (req_value == '0);
   assign status.top_zero = (top_digit == 4'd0);
   assign status.out_free = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_char   = char_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

### hw/rtl/i2a_ctrl.sv
// Controller of the integer-to-ASCII formatter: sequences conversion, prefix,
// digit scan with leading-zero skip, and the null-pointer text.
// Depends on i2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2a_ctrl
   import i2a_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [2:0] req_op,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_PRE,
      ST_DIGITS,
      ST_NIL
   } state_type;

   localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_W - 1);
   localparam logic [CNT_W-1:0] DIG_FIRST = CNT_W'(NUM_DIGITS - 1);
   localparam logic [CNT_W-1:0] NIL_LAST  = CNT_W'(NIL_LEN - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             minus_ff, minus_in;
   logic             ptr_ff, ptr_in;
   logic             upper_ff, upper_in;
   logic             started_ff, started_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      minus_in   = minus_ff;
      ptr_in     = ptr_ff;
      upper_in   = upper_ff;
      started_in = started_ff;
      cmd        = '0;
      cmd.upper  = upper_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               minus_in   = 1'b0;
               ptr_in     = 1'b0;
               upper_in   = 1'b0;
               started_in = 1'b0;
               cnt_in     = '0;
               unique case (req_op)
                  OP_SDEC: begin
                     minus_in     = status.val_neg;
                     cmd.load_dec = 1'b1;
                     cmd.negate   = status.val_neg;
                     state_in     = ST_CONV;
                  end
                  OP_LHEX: begin
                     cmd.load_hex = 1'b1;
                     cnt_in       = DIG_FIRST;
                     state_in     = ST_DIGITS;
                  end
                  OP_UHEX: begin
                     cmd.load_hex = 1'b1;
                     upper_in     = 1'b1;
                     cnt_in       = DIG_FIRST;
                     state_in     = ST_DIGITS;
                  end
                  OP_PTR: begin
                     if (status.val_zero) begin
                        state_in = ST_NIL;
                     end else begin
                        cmd.load_hex = 1'b1;
                        ptr_in       = 1'b1;
                        state_in     = ST_PRE;
                     end
                  end
                  default: begin
                     cmd.load_dec = 1'b1;
                     state_in     = ST_CONV;
                  end
               endcase
            end
         end

         // One double-dabble step per cycle over all magnitude bits.
         ST_CONV: begin
            cmd.dabble = 1'b1;
            if (cnt_ff == CONV_LAST) begin
               state_in = minus_ff ? ST_PRE : ST_DIGITS;
               cnt_in   = minus_ff ? '0 : DIG_FIRST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Sign or "0x" prefix.
         ST_PRE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (!ptr_ff) begin
                  cmd.lit_char = CHAR_MINUS;
                  state_in     = ST_DIGITS;
                  cnt_in       = DIG_FIRST;
               end else if (cnt_ff[0]) begin
                  cmd.lit_char = CHAR_X;
                  state_in     = ST_DIGITS;
                  cnt_in       = DIG_FIRST;
               end else begin
                  cmd.lit_char = CHAR_ZERO;
                  cnt_in       = cnt_ff + 1'b1;
               end
            end
         end

         // Scan digits from the top; leading zeros are dropped, the
         // lowest digit always prints.
         ST_DIGITS: begin
            if (!started_ff && status.top_zero && cnt_ff != '0) begin
               cmd.step = 1'b1;
               cnt_in   = cnt_ff - 1'b1;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.use_digit = 1'b1;
               cmd.step      = 1'b1;
               cmd.last      = (cnt_ff == '0);
               started_in    = 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end

         ST_NIL: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.lit_char = nil_char(cnt_ff[2:0]);
               cmd.last     = (cnt_ff == NIL_LAST);
               if (cnt_ff == NIL_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         minus_ff   <= 1'b0;
         ptr_ff     <= 1'b0;
         upper_ff   <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         minus_ff   <= minus_in;
         ptr_ff     <= ptr_in;
         upper_ff   <= upper_in;
         started_ff <= started_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/integer_to_ascii_formatter_core.sv
// Integer-to-ASCII formatter: one 64-bit value in, its text out one character per transfer.
// Decimal kinds run a serial double-dabble over all 64 value bits after acceptance, then a
// digit scan over the 20 digit positions plus any prefix character; hex kinds skip the
// conversion. The null pointer gives the text (nil). One item is worked at a time; output
// stalls extend it.
// Synchronous active-high reset empties the output register and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_core
   import i2a_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [VALUE_W-1:0] req_tdata,   // [63:0] value
   input  wire logic [2:0]         req_tuser,   // [2:0] op
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] out_char
   output logic                    rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   // Sequencing control.
   i2a_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // Conversion registers and output register.
   i2a_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_char   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

   // An accepted item keeps the input side closed on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted again right after a transfer");

   // Emitting the final character returns the block to idle.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> req_tready)
      else $error("block not idle after the final character");

   // No character is produced during the binary-to-decimal conversion.
   a_no_emit_in_conv: assert property (@(posedge clock) disable iff (reset)
      cmd.dabble |-> !cmd.emit && !req_tready)
      else $error("emit or accept during conversion");

   // A new character is loaded only when the output register is free.
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_tvalid || rsp_tready)
      else $error("output register overwritten");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for integer_to_ascii_formatter_core.
// Streams numbers of every conversion kind and compares each output character
// against a local text formatter; depends only on the i2a_pkg package and the core.
`timescale 1ns / 1ps

module tb_top
   import i2a_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 120;
   localparam int RANDOM_ITEMS   = 480;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [2:0]         kind;
   } number_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata = '0;   // [63:0] value
   logic [2:0]         req_tuser = '0;   // [2:0] op
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;        // [7:0] out_char
   logic               rsp_tlast;

   number_item_type numbers_to_send[$];
   text_char_type   expected_text[$];
   int              numbers_accepted = 0;
   int              error_count = 0;
   int              send_pause = 0;
   int              sink_stall = 0;
   int              idle_cycles = 0;

   integer_to_ascii_formatter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Pause lengths: mostly short, a few long, and none at all in quiet windows.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (((numbers_accepted / 64) % 4) == 2) begin
         return 0;
      end
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 150);
   endfunction

   // ASCII text of one digit value.
   function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input bit upper);
      if (d < 4'd10) begin
         return 8'h30 + {4'd0, d};
      end
      return (upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
   endfunction

   // Works out the characters one number produces and queues them in order.
   task automatic format_number(input logic [VALUE_W-1:0] v, input logic [2:0] kind);
      logic [7:0]         text[$];
      logic [7:0]         digits[$];
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] radix;
      bit                 upper;
      string              nil_text;
      text_char_type      tc;
      nil_text = "(nil)";
      mag = v;
      radix = 64'd10;
      upper = 1'b0;
      if (kind == OP_PTR && v == '0) begin
         for (int i = 0; i < nil_text.len(); i++) begin
            text.push_back(nil_text[i]);
         end
      end else begin
         case (kind)
            OP_SDEC: begin
               if (v[VALUE_W-1]) begin
                  text.push_back(8'h2D);
                  mag = ~v + 64'd1;
               end
            end
            OP_LHEX: radix = 64'd16;
            OP_UHEX: begin
               radix = 64'd16;
               upper = 1'b1;
            end
            OP_PTR: begin
               radix = 64'd16;
               text.push_back(8'h30);
               text.push_back(8'h78);
            end
            default: radix = 64'd10;   // unsigned decimal, also the unused codes
         endcase
         // Digits come out least significant first, so build them from the front.
         do begin
            digits.push_front(digit_to_ascii(4'(mag % radix), upper));
            mag = mag / radix;
         end while (mag != '0);
         foreach (digits[i]) begin
            text.push_back(digits[i]);
         end
      end
      foreach (text[i]) begin
         tc.ch = text[i];
         tc.last = (i == text.size() - 1);
         expected_text.push_back(tc);
      end
   endtask

   task automatic add_number(input logic [VALUE_W-1:0] v, input logic [2:0] kind);
      number_item_type item;
      item.value = v;
      item.kind = kind;
      numbers_to_send.push_back(item);
   endtask

   // Random value shaped to hit short, long, negative and boundary texts.
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      int                 k;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 1000));
         2: begin
            v = 64'd1 << $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1) begin
               v = v - 64'd1;
            end
         end
         3: v = ~64'($urandom_range(0, 1000)) + 64'd1;
         4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: begin
            v = 64'd1;
            k = $urandom_range(0, 19);
            repeat (k) v = v * 64'd10;
            v = v + 64'($urandom_range(0, 2)) - 64'd1;
         end
      endcase
      return v;
   endfunction

   function automatic logic [2:0] random_kind();
      if ($urandom_range(0, 15) == 0) begin
         return 3'($urandom_range(5, 7));
      end
      return 3'($urandom_range(0, 4));
   endfunction

   // Input driver: presents queued numbers with random pauses between transfers.
   always @(posedge clock) begin
      number_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            format_number(req_tdata, req_tuser);
            numbers_accepted++;
         end
         if (req_tvalid && !req_tready) begin
            // Hold the current item until it is taken.
         end else if (send_pause > 0) begin
            send_pause--;
            req_tvalid <= 1'b0;
         end else if (numbers_to_send.size() > 0) begin
            item = numbers_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.value;
            req_tuser <= item.kind;
            send_pause = pick_pause();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Output monitor: checks every character transfer and stalls at random.
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected character %h last %b", $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               if (want.ch !== rsp_tdata) begin
                  $display("%0t: char mismatch expected %h actual %h",
                           $time, want.ch, rsp_tdata);
                  error_count++;
               end
               if (want.last !== rsp_tlast) begin
                  $display("%0t: last mismatch expected %b actual %b",
                           $time, want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               sink_stall = pick_pause();
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Stimulus list, reset and end of run.
   initial begin
      int total_numbers;
      // Zero in every kind, including the null pointer.
      add_number(64'd0, OP_SDEC);
      add_number(64'd0, OP_UDEC);
      add_number(64'd0, OP_LHEX);
      add_number(64'd0, OP_UHEX);
      add_number(64'd0, OP_PTR);
      // Signed extremes, the most negative value among them.
      add_number(64'h7FFF_FFFF_FFFF_FFFF, OP_SDEC);
      add_number(64'h8000_0000_0000_0000, OP_SDEC);
      add_number(64'hFFFF_FFFF_FFFF_FFFF, OP_SDEC);
      add_number(64'd1, OP_SDEC);
      // All ones in the unsigned kinds gives the longest texts.
      add_number(64'hFFFF_FFFF_FFFF_FFFF, OP_UDEC);
      add_number(64'hFFFF_FFFF_FFFF_FFFF, OP_LHEX);
      add_number(64'hFFFF_FFFF_FFFF_FFFF, OP_UHEX);
      add_number(64'hFFFF_FFFF_FFFF_FFFF, OP_PTR);
      add_number(64'h8000_0000_0000_0000, OP_UDEC);
      add_number(64'hDEAD_BEEF_CAFE_BABE, OP_LHEX);
      add_number(64'hDEAD_BEEF_CAFE_BABE, OP_UHEX);
      add_number(64'h0000_0000_0000_0ABC, OP_PTR);
      add_number(64'd1, OP_PTR);
      add_number(64'd9999999999999999999, OP_UDEC);
      add_number(64'd10000000000000000000, OP_UDEC);
      // Unused kind codes fall back to unsigned decimal.
      add_number(64'hFFFF_FFFF_FFFF_FFFF, 3'd5);
      add_number(64'd0, 3'd6);
      add_number(64'd12345, 3'd7);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_number(random_value(), random_kind());
      end
      total_numbers = numbers_to_send.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every number must be taken and every expected character seen.
      while (numbers_accepted < total_numbers || expected_text.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_datapath.sv
hw/rtl/i2a_ctrl.sv
hw/rtl/integer_to_ascii_formatter_core.sv
sim/tb_top.sv
